// ===== rtl/core/sdsps_pkg.sv =====
// shared types, constants and helper functions of the servo pulse scheduler
// no dependencies; imported by every other file of the block
package sdsps_pkg;

  localparam int CHANNELS_DEF = 8;

  localparam int FUNC_W     = 2;
  localparam int CHAN_W     = 3;
  localparam int UNITS_W    = 8;
  localparam int TICKS_W    = 8;
  localparam int GAP_W      = 16;
  localparam int WIDTH_W    = 13;
  localparam int MASK_W     = 8;
  localparam int RELOAD_W   = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [FUNC_W-1:0] FUNC_SET    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_COMMIT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_EXPIRY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_UNIT_TICKS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_GAP  = 1'b1;

  localparam logic [UNITS_W-1:0] WIDTH_MIN = 8'd10;
  localparam logic [UNITS_W-1:0] WIDTH_MAX = 8'd20;

  localparam int WIDTH_MID_UNITS = 15;
  localparam int FRAME_GAP_UNITS = 19;

  localparam logic [TICKS_W-1:0] UNIT_TICKS_RESET = TICKS_W'(15);
  localparam logic [GAP_W-1:0]   FRAME_GAP_RESET  = GAP_W'(FRAME_GAP_UNITS * 150);
  localparam logic [WIDTH_W-1:0] WIDTH_MID_TICKS  =
    WIDTH_W'(WIDTH_MID_UNITS * int'(UNIT_TICKS_RESET));

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [CHAN_W-1:0]  channel;
    logic [UNITS_W-1:0] width_units;
  } item_t;

  typedef struct packed {
    logic [MASK_W-1:0]   raise_mask;
    logic [MASK_W-1:0]   lower_mask;
    logic [RELOAD_W-1:0] reload;
    logic                reload_valid;
    logic                rejected;
  } res_t;

  typedef struct packed {
    logic [WIDTH_W-1:0] a;
    logic [WIDTH_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic               lt;
    logic               eq;
    logic [WIDTH_W-1:0] diff;
  } alu_rsp_t;

  // pin bit of one channel, channels past the mask width have no pin
  function automatic logic [MASK_W-1:0] chan_bit(input int unsigned c);
    logic [MASK_W-1:0] m;
    m = '0;
    if (c < MASK_W) m[c] = 1'b1;
    return m;
  endfunction

  function automatic logic [MASK_W-1:0] all_mask(input int unsigned n);
    logic [MASK_W-1:0] m;
    m = '0;
    for (int unsigned c = 0; c < MASK_W; c++) begin
      if (c < n) m[c] = 1'b1;
    end
    return m;
  endfunction

endpackage

// ===== rtl/core/sdsps_if.sv =====
// valid/ready channel interfaces for scheduler items and results
// depends on sdsps_pkg for the field widths
interface sdsps_in_if;
  import sdsps_pkg::*;

  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [CHAN_W-1:0]  channel;
  logic [UNITS_W-1:0] width_units;

  modport source (output valid, func, channel, width_units, input ready);
  modport sink   (input valid, func, channel, width_units, output ready);
endinterface

interface sdsps_out_if;
  import sdsps_pkg::*;

  logic                valid;
  logic                ready;
  logic [MASK_W-1:0]   raise_mask;
  logic [MASK_W-1:0]   lower_mask;
  logic [RELOAD_W-1:0] reload;
  logic                reload_valid;
  logic                rejected;

  modport source (output valid, raise_mask, lower_mask, reload, reload_valid, rejected,
                  input ready);
  modport sink   (input valid, raise_mask, lower_mask, reload, reload_valid, rejected,
                  output ready);
endinterface

// ===== rtl/core/sorted_delta_servo_pulse_scheduler.sv =====
// top level of the servo pulse scheduler: channels, configuration registers, result register
// depends on sdsps_pkg, sdsps_if, sdsps_alu and sdsps_ctrl

// One shared reload timer drives up to CHANNELS servo pins. A set item stores a channel's
// width (10 to 20 units, times unit_ticks); a bad width or channel is answered with
// rejected. A commit item ranks the stored widths one compare per cycle on the shared
// compare/subtract unit, then rewrites the sorted widths as deltas. A timer expiry item
// raises all pins in a start phase; in a stop phase it lowers the next channel and every
// further channel that ends at the same time. One item is worked on at a time; ready is
// low while it runs, and the result register lets the next item in while a result waits.
// Widths are stored in ticks, so a later change of unit_ticks affects only new sets.
module sorted_delta_servo_pulse_scheduler #(
  parameter int CHANNELS = sdsps_pkg::CHANNELS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  sdsps_in_if.sink                           in_ch,
  sdsps_out_if.source                        out_ch,
  input  logic                               cfg_we,
  input  logic [sdsps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sdsps_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import sdsps_pkg::*;

  logic [TICKS_W-1:0] unit_ticks_r;
  logic [GAP_W-1:0]   frame_gap_r;
  logic               out_valid_r;
  res_t               out_res_r;

  item_t    item;
  res_t     res;
  alu_req_t alu_req;
  alu_rsp_t alu_rsp;
  logic     idle, item_valid, out_free, res_load;

  assign item.func        = in_ch.func;
  assign item.channel     = in_ch.channel;
  assign item.width_units = in_ch.width_units;
  assign in_ch.ready      = idle;
  assign item_valid       = in_ch.valid & idle;
  assign out_free         = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_ticks_r <= UNIT_TICKS_RESET;
      frame_gap_r  <= FRAME_GAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_UNIT_TICKS: unit_ticks_r <= cfg_data[TICKS_W-1:0];
        CFG_FRAME_GAP:  frame_gap_r  <= cfg_data[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) out_res_r <= res;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.raise_mask   = out_res_r.raise_mask;
  assign out_ch.lower_mask   = out_res_r.lower_mask;
  assign out_ch.reload       = out_res_r.reload;
  assign out_ch.reload_valid = out_res_r.reload_valid;
  assign out_ch.rejected     = out_res_r.rejected;

  sdsps_ctrl #(
    .CHANNELS (CHANNELS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .idle       (idle),
    .unit_ticks (unit_ticks_r),
    .frame_gap  (frame_gap_r),
    .out_free   (out_free),
    .res_load   (res_load),
    .res        (res),
    .alu_req    (alu_req),
    .alu_rsp    (alu_rsp)
  );

  sdsps_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

endmodule

// ===== rtl/core/sdsps_alu.sv =====
// shared compare and subtract unit of the scheduler
// depends on sdsps_pkg for the request and response structs
module sdsps_alu (
  input  sdsps_pkg::alu_req_t req,
  output sdsps_pkg::alu_rsp_t rsp
);
  import sdsps_pkg::*;

  always_comb begin
    rsp.lt   = (req.a < req.b);
    rsp.eq   = (req.a == req.b);
    rsp.diff = req.a - req.b;
  end

endmodule

// ===== rtl/core/sdsps_ctrl.sv =====
// sequencer and tables of the scheduler: width table, rank sort, delta pass, expiry walk
// depends on sdsps_pkg; drives the shared sdsps_alu
module sdsps_ctrl #(
  parameter int CHANNELS = sdsps_pkg::CHANNELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            item_valid,
  input  sdsps_pkg::item_t                item,
  output logic                            idle,
  input  logic [sdsps_pkg::TICKS_W-1:0]   unit_ticks,
  input  logic [sdsps_pkg::GAP_W-1:0]     frame_gap,
  input  logic                            out_free,
  output logic                            res_load,
  output sdsps_pkg::res_t                 res,
  output sdsps_pkg::alu_req_t             alu_req,
  input  sdsps_pkg::alu_rsp_t             alu_rsp
);
  import sdsps_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W = $clog2(CHANNELS + 1);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(CHANNELS - 1);
  localparam logic [CNT_W-1:0] NCH  = CNT_W'(CHANNELS);

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_LOADK     = 4'd1;
  localparam logic [3:0] ST_SCAN      = 4'd2;
  localparam logic [3:0] ST_PLACE     = 4'd3;
  localparam logic [3:0] ST_DELTA     = 4'd4;
  localparam logic [3:0] ST_EXP_START = 4'd5;
  localparam logic [3:0] ST_EXP_LOW   = 4'd6;
  localparam logic [3:0] ST_EXP_CHK   = 4'd7;
  localparam logic [3:0] ST_FINISH    = 4'd8;

  logic [3:0]         state_r, state_nxt;
  logic [WIDTH_W-1:0] pend_r  [CHANNELS];
  logic [WIDTH_W-1:0] delay_r [CHANNELS];
  logic [IDX_W-1:0]   order_r [CHANNELS];
  logic               phase_r, phase_nxt;
  logic [CNT_W-1:0]   slot_r, slot_nxt;
  logic [CNT_W-1:0]   s_r, s_nxt;
  logic [IDX_W-1:0]   i_r, i_nxt;
  logic [IDX_W-1:0]   j_r, j_nxt;
  logic [IDX_W-1:0]   k_r, k_nxt;
  logic [IDX_W-1:0]   rank_r, rank_nxt;
  logic [WIDTH_W-1:0] kw_r, kw_nxt;
  logic [WIDTH_W-1:0] prev_r, prev_nxt;
  res_t               res_r, res_nxt;

  logic [IDX_W-1:0]   pend_raddr, act_raddr, pend_waddr, act_waddr;
  logic [WIDTH_W-1:0] pend_rd, delay_rd, pend_wdata, delay_wdata;
  logic [IDX_W-1:0]   order_rd, order_wdata;
  logic               pend_we, delay_we, order_we;
  logic               set_bad;
  logic [15:0]        prod;

  assign pend_rd  = pend_r[pend_raddr];
  assign delay_rd = delay_r[act_raddr];
  assign order_rd = order_r[act_raddr];

  assign idle = (state_r == ST_IDLE);
  assign res  = res_r;

  assign prod    = 16'(item.width_units) * 16'(unit_ticks);
  assign set_bad = (item.width_units < WIDTH_MIN) || (item.width_units > WIDTH_MAX) ||
                   (32'(item.channel) >= CHANNELS);

  always_comb begin
    state_nxt   = state_r;
    phase_nxt   = phase_r;
    slot_nxt    = slot_r;
    s_nxt       = s_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    k_nxt       = k_r;
    rank_nxt    = rank_r;
    kw_nxt      = kw_r;
    prev_nxt    = prev_r;
    res_nxt     = res_r;
    res_load    = 1'b0;
    pend_we     = 1'b0;
    pend_waddr  = IDX_W'(item.channel);
    pend_wdata  = prod[WIDTH_W-1:0];
    delay_we    = 1'b0;
    order_we    = 1'b0;
    act_waddr   = rank_r;
    delay_wdata = kw_r;
    order_wdata = i_r;

    pend_raddr = (state_r == ST_SCAN) ? j_r : i_r;
    case (state_r)
      ST_DELTA:     act_raddr = k_r;
      ST_EXP_START: act_raddr = '0;
      default:      act_raddr = s_r[IDX_W-1:0];
    endcase

    alu_req.a = (state_r == ST_SCAN) ? pend_rd : delay_rd;
    alu_req.b = (state_r == ST_SCAN)  ? kw_r :
                (state_r == ST_DELTA) ? prev_r : '0;

    unique case (state_r)
      ST_IDLE: begin
        if (item_valid) begin
          res_nxt = '0;
          unique case (item.func)
            FUNC_SET: begin
              pend_we          = !set_bad;
              res_nxt.rejected = set_bad;
              state_nxt        = ST_FINISH;
            end
            FUNC_COMMIT: begin
              i_nxt     = '0;
              state_nxt = ST_LOADK;
            end
            FUNC_EXPIRY: begin
              res_nxt.reload_valid = 1'b1;
              if (!phase_r) begin
                state_nxt = ST_EXP_START;
              end else begin
                s_nxt     = (slot_r >= NCH) ? '0 : slot_r;
                state_nxt = ST_EXP_LOW;
              end
            end
            default: state_nxt = ST_FINISH;
          endcase
        end
      end
      ST_LOADK: begin
        kw_nxt    = pend_rd;
        j_nxt     = '0;
        rank_nxt  = '0;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        // stable rank: smaller widths, or equal widths of lower channels
        if (alu_rsp.lt || (alu_rsp.eq && (j_r < i_r))) rank_nxt = rank_r + 1'b1;
        if (j_r == LAST) state_nxt = ST_PLACE;
        else j_nxt = j_r + 1'b1;
      end
      ST_PLACE: begin
        delay_we = 1'b1;
        order_we = 1'b1;
        if (i_r == LAST) begin
          k_nxt     = '0;
          prev_nxt  = '0;
          state_nxt = ST_DELTA;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_LOADK;
        end
      end
      ST_DELTA: begin
        // sorted absolute widths turned into deltas in place
        delay_we    = 1'b1;
        act_waddr   = k_r;
        delay_wdata = alu_rsp.diff;
        prev_nxt    = delay_rd;
        if (k_r == LAST) state_nxt = ST_FINISH;
        else k_nxt = k_r + 1'b1;
      end
      ST_EXP_START: begin
        res_nxt.raise_mask = all_mask(CHANNELS);
        res_nxt.reload     = RELOAD_W'(delay_rd);
        slot_nxt           = '0;
        phase_nxt          = 1'b1;
        state_nxt          = ST_FINISH;
      end
      ST_EXP_LOW: begin
        res_nxt.lower_mask = res_r.lower_mask | chan_bit(32'(order_rd));
        s_nxt              = s_r + 1'b1;
        state_nxt          = ST_EXP_CHK;
      end
      ST_EXP_CHK: begin
        if (s_r >= NCH) begin
          phase_nxt      = 1'b0;
          slot_nxt       = '0;
          res_nxt.reload = frame_gap;
          state_nxt      = ST_FINISH;
        end else if (alu_rsp.eq) begin
          // zero delay: this channel ends together with the previous one
          res_nxt.lower_mask = res_r.lower_mask | chan_bit(32'(order_rd));
          s_nxt              = s_r + 1'b1;
        end else begin
          slot_nxt       = s_r;
          res_nxt.reload = RELOAD_W'(delay_rd);
          state_nxt      = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          res_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= 1'b0;
      slot_r  <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      slot_r  <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r    <= s_nxt;
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    k_r    <= k_nxt;
    rank_r <= rank_nxt;
    kw_r   <= kw_nxt;
    prev_r <= prev_nxt;
    res_r  <= res_nxt;
  end

  // tables reset to the schedule of all middle widths
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        pend_r[c]  <= WIDTH_MID_TICKS;
        delay_r[c] <= (c == 0) ? WIDTH_MID_TICKS : '0;
        order_r[c] <= IDX_W'(c);
      end
    end else begin
      if (pend_we)  pend_r[pend_waddr] <= pend_wdata;
      if (delay_we) delay_r[act_waddr] <= delay_wdata;
      if (order_we) order_r[act_waddr] <= order_wdata;
    end
  end

endmodule

// ===== rtl/core/sdsps_checker.sv =====
// port-level checks of the servo pulse scheduler and their bind to the top level
// depends on sdsps_pkg and sorted_delta_servo_pulse_scheduler
module sdsps_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [sdsps_pkg::MASK_W-1:0]    raise_mask,
  input logic [sdsps_pkg::MASK_W-1:0]    lower_mask,
  input logic [sdsps_pkg::RELOAD_W-1:0]  reload,
  input logic                            reload_valid,
  input logic                            rejected
);
  import sdsps_pkg::*;

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // one item at a time: busy right after an input transfer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in work");

  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && rejected |->
      !reload_valid && (raise_mask == '0) && (lower_mask == '0) && (reload == '0))
    else $error("rejected result carries timer fields");

  a_phase_masks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((raise_mask != '0) || (lower_mask != '0)) |->
      reload_valid && ((raise_mask == '0) || (lower_mask == '0)))
    else $error("pins raised and lowered in one result, or outside an expiry");

  a_reload_only_on_expiry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !reload_valid |-> (reload == '0))
    else $error("reload set on a non-expiry result");

endmodule

bind sorted_delta_servo_pulse_scheduler sdsps_checker u_sdsps_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .raise_mask   (out_ch.raise_mask),
  .lower_mask   (out_ch.lower_mask),
  .reload       (out_ch.reload),
  .reload_valid (out_ch.reload_valid),
  .rejected     (out_ch.rejected)
);

// ===== test/sorted_delta_servo_pulse_scheduler_test.sv =====
`timescale 1ns / 1ps
// self-checking bench for the servo pulse scheduler: a directed table, then random traffic
// checked against a schedule model kept here; needs sdsps_pkg, sdsps_if and the rtl
module sorted_delta_servo_pulse_scheduler_test;
  import sdsps_pkg::*;

  localparam int NCH = CHANNELS_DEF;
  localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;
  localparam int ITEMS_PER_PHASE = 188;
  localparam int NUM_PHASES = 6;
  localparam int DRAIN_CYCLES = 100;
  localparam int MAX_PRINTS = 40;
  localparam logic TYPED = 1'b1;
  localparam logic MODELED = 1'b0;
  localparam res_t RES_IDLE = '0;
  localparam res_t RES_REJECT = res_t'({8'h00, 8'h00, 16'h0000, 1'b0, 1'b1});

  typedef struct packed {
    item_t it;
    logic  known;
    res_t  want;
  } plan_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  sdsps_in_if  in_ch();
  sdsps_out_if out_ch();

  sorted_delta_servo_pulse_scheduler #(.CHANNELS(NCH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // schedule model state
  logic [TICKS_W-1:0] unit_ticks_m;
  logic [GAP_W-1:0]   frame_gap_m;
  logic [WIDTH_W-1:0] pend_ticks [NCH];
  logic [WIDTH_W-1:0] sched_delay [NCH];
  logic [CHAN_W-1:0]  sched_chan [NCH];
  logic               stop_phase;
  int unsigned        slot_ptr;

  res_t        pin_event_q [$];
  plan_row_t   plan [$];
  int unsigned err_count = 0;
  int unsigned result_count = 0;
  int unsigned send_idle_pct = 21;
  int unsigned recv_idle_pct = 79;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void rebuild_schedule();
    logic [WIDTH_W-1:0] w [NCH];
    logic [CHAN_W-1:0]  ch [NCH];
    logic [WIDTH_W-1:0] prev;
    int j;
    for (int i = 0; i < NCH; i++) begin
      j = i;
      // strict compare keeps equal widths in channel order
      while (j > 0 && w[j-1] > pend_ticks[i]) begin
        w[j] = w[j-1];
        ch[j] = ch[j-1];
        j--;
      end
      w[j] = pend_ticks[i];
      ch[j] = CHAN_W'(i);
    end
    prev = '0;
    for (int i = 0; i < NCH; i++) begin
      sched_delay[i] = w[i] - prev;
      sched_chan[i] = ch[i];
      prev = w[i];
    end
  endfunction

  function automatic res_t schedule_step(input item_t it);
    res_t r;
    int unsigned s;
    r = '0;
    case (it.func)
      FUNC_SET: begin
        if (it.width_units < WIDTH_MIN || it.width_units > WIDTH_MAX) begin
          r.rejected = 1'b1;
        end else begin
          pend_ticks[it.channel] = WIDTH_W'(int'(it.width_units) * int'(unit_ticks_m));
        end
      end
      FUNC_COMMIT: begin
        rebuild_schedule();
      end
      FUNC_EXPIRY: begin
        r.reload_valid = 1'b1;
        if (!stop_phase) begin
          r.raise_mask = '1;
          r.reload = RELOAD_W'(sched_delay[0]);
          slot_ptr = 0;
          stop_phase = 1'b1;
        end else begin
          s = (slot_ptr < NCH) ? slot_ptr : 0;
          r.lower_mask[sched_chan[s]] = 1'b1;
          s++;
          // channels ending on the same tick drop together
          while (s < NCH && sched_delay[s] == '0) begin
            r.lower_mask[sched_chan[s]] = 1'b1;
            s++;
          end
          if (s >= NCH) begin
            stop_phase = 1'b0;
            slot_ptr = 0;
            r.reload = frame_gap_m;
          end else begin
            slot_ptr = s;
            r.reload = RELOAD_W'(sched_delay[s]);
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_miss(input string line);
    if (err_count < MAX_PRINTS) $display("mismatch: %s", line);
    err_count++;
  endtask

  // valid stays high across back-to-back transfers, dropped only in a gap
  task automatic push_item(input item_t it, input logic known, input res_t want);
    res_t got;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= it.func;
    in_ch.channel <= it.channel;
    in_ch.width_units <= it.width_units;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    got = schedule_step(it);
    pin_event_q.push_back(known ? want : got);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pin_event_q.size() != 0);
  endtask

  // result side: random stalls, every transfer compared with the oldest expectation
  initial begin
    res_t want;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (pin_event_q.size() == 0) begin
          report_miss($sformatf("result %0d arrived with nothing expected", result_count));
        end else begin
          want = pin_event_q.pop_front();
          if (out_ch.raise_mask !== want.raise_mask)
            report_miss($sformatf("result %0d raise_mask %h, want %h",
                                  result_count, out_ch.raise_mask, want.raise_mask));
          if (out_ch.lower_mask !== want.lower_mask)
            report_miss($sformatf("result %0d lower_mask %h, want %h",
                                  result_count, out_ch.lower_mask, want.lower_mask));
          if (out_ch.reload !== want.reload)
            report_miss($sformatf("result %0d reload %0d, want %0d",
                                  result_count, out_ch.reload, want.reload));
          if (out_ch.reload_valid !== want.reload_valid)
            report_miss($sformatf("result %0d reload_valid %b, want %b",
                                  result_count, out_ch.reload_valid, want.reload_valid));
          if (out_ch.rejected !== want.rejected)
            report_miss($sformatf("result %0d rejected %b, want %b",
                                  result_count, out_ch.rejected, want.rejected));
        end
        result_count++;
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    item_t it;
    int unsigned pick;
    logic [TICKS_W-1:0] ticks;
    logic [GAP_W-1:0] gap;

    in_ch.valid <= 1'b0;
    in_ch.func <= FUNC_SET;
    in_ch.channel <= '0;
    in_ch.width_units <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_UNIT_TICKS;
    cfg_data <= '0;
    rst_n <= 1'b0;

    unit_ticks_m = UNIT_TICKS_RESET;
    frame_gap_m = FRAME_GAP_RESET;
    for (int i = 0; i < NCH; i++) pend_ticks[i] = WIDTH_MID_TICKS;
    rebuild_schedule();
    stop_phase = 1'b0;
    slot_ptr = 0;

    // reset schedule: all channels at mid width, so the first stop drops every pin
    plan.push_back({FUNC_EXPIRY, 3'd0, 8'd0, TYPED, 8'hFF, 8'h00, 16'd225, 1'b1, 1'b0});
    plan.push_back({FUNC_EXPIRY, 3'd0, 8'd0, TYPED, 8'h00, 8'hFF, 16'd2850, 1'b1, 1'b0});
    plan.push_back({FUNC_NONE, 3'd7, 8'd255, TYPED, RES_IDLE});
    plan.push_back({FUNC_SET, 3'd0, 8'd9, TYPED, RES_REJECT});
    plan.push_back({FUNC_SET, 3'd7, 8'd21, TYPED, RES_REJECT});
    plan.push_back({FUNC_SET, 3'd5, 8'd0, TYPED, RES_REJECT});
    plan.push_back({FUNC_SET, 3'd2, 8'd255, TYPED, RES_REJECT});
    plan.push_back({FUNC_SET, 3'd7, 8'd20, TYPED, RES_IDLE});
    plan.push_back({FUNC_SET, 3'd0, 8'd10, TYPED, RES_IDLE});
    // equal widths on channels 0 and 3, and on 4 and 7
    plan.push_back({FUNC_SET, 3'd3, 8'd10, TYPED, RES_IDLE});
    plan.push_back({FUNC_SET, 3'd4, 8'd20, TYPED, RES_IDLE});
    plan.push_back({FUNC_COMMIT, 3'd0, 8'd0, TYPED, RES_IDLE});
    plan.push_back({FUNC_EXPIRY, 3'd0, 8'd0, MODELED, RES_IDLE});
    plan.push_back({FUNC_EXPIRY, 3'd0, 8'd0, MODELED, RES_IDLE});
    // new schedule committed with the frame half done
    plan.push_back({FUNC_SET, 3'd1, 8'd12, MODELED, RES_IDLE});
    plan.push_back({FUNC_SET, 3'd6, 8'd18, MODELED, RES_IDLE});
    plan.push_back({FUNC_COMMIT, 3'd0, 8'd0, MODELED, RES_IDLE});
    for (int k = 0; k < 5; k++)
      plan.push_back({FUNC_EXPIRY, 3'd0, 8'd0, MODELED, RES_IDLE});
    plan.push_back({FUNC_COMMIT, 3'd0, 8'd0, MODELED, RES_IDLE});
    plan.push_back({FUNC_EXPIRY, 3'd0, 8'd0, MODELED, RES_IDLE});

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[k]) push_item(plan[k].it, plan[k].known, plan[k].want);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      repeat (4) @(posedge clk);
      case (p)
        0: begin
          ticks = 8'd255;
          gap = 16'hFFFF;
        end
        1: begin
          ticks = 8'd1;
          gap = 16'd1;
        end
        2: begin
          // zero ticks per unit, new widths collapse to zero-length pulses
          ticks = 8'd0;
          gap = GAP_W'($urandom_range(65535, 1));
        end
        5: begin
          ticks = UNIT_TICKS_RESET;
          gap = FRAME_GAP_RESET;
        end
        default: begin
          ticks = TICKS_W'($urandom_range(255, 1));
          gap = GAP_W'($urandom_range(65535, 1));
        end
      endcase
      cfg_we <= 1'b1;
      cfg_index <= CFG_UNIT_TICKS;
      cfg_data <= CFG_DATA_W'(ticks);
      @(posedge clk);
      cfg_index <= CFG_FRAME_GAP;
      cfg_data <= gap;
      @(posedge clk);
      cfg_we <= 1'b0;
      unit_ticks_m = ticks;
      frame_gap_m = gap;

      send_idle_pct = (p < 2) ? 21 : (p < 4) ? 79 : 0;
      recv_idle_pct = (p < 2) ? 79 : (p < 4) ? 21 : 0;

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n == ITEMS_PER_PHASE / 2) drain_results();
        pick = $urandom_range(99);
        it.channel = CHAN_W'($urandom_range(NCH - 1));
        it.width_units = UNITS_W'($urandom_range(int'(WIDTH_MAX), int'(WIDTH_MIN)));
        if (pick < 48) begin
          it.func = FUNC_EXPIRY;
        end else if (pick < 82) begin
          it.func = FUNC_SET;
          // some widths anywhere in the field, mostly out of range
          if ($urandom_range(9) == 0) it.width_units = UNITS_W'($urandom_range(255));
        end else if (pick < 96) begin
          it.func = FUNC_COMMIT;
        end else begin
          it.func = FUNC_NONE;
        end
        push_item(it, MODELED, RES_IDLE);
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("sorted_delta_servo_pulse_scheduler regression: pass");
    end else begin
      $display("sorted_delta_servo_pulse_scheduler regression: fail");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin
    #20_000_000;
    $display("sorted_delta_servo_pulse_scheduler regression: fail");
    $finish;
  end

endmodule
